>>> rtl/core/cmap_pkg.sv
package cmap_pkg;

  // Width of the normalized fraction; 1.0 is one above the top fraction bit.
  localparam int unsigned NORM_BITS = 16;
  localparam int unsigned NORM_W    = NORM_BITS + 1;
  localparam logic [NORM_BITS:0] NORM_ONE = {1'b1, {NORM_BITS{1'b0}}};

  // Quarter-sine Horner coefficients, Q30, (pi/2)^k / k!
  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026996;
  localparam logic [30:0] SIN_C9 = 31'd172272;

  // Curve codes; codes above CURVE_SINE act as linear.
  localparam logic [2:0] CURVE_LINEAR = 3'd0;
  localparam logic [2:0] CURVE_SQUARE = 3'd1;
  localparam logic [2:0] CURVE_SQRT   = 3'd2;
  localparam logic [2:0] CURVE_SMOOTH = 3'd3;
  localparam logic [2:0] CURVE_SINE   = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_INPUT_LOW   = 3'd0;
  localparam logic [2:0] REG_INPUT_HIGH  = 3'd1;
  localparam logic [2:0] REG_CURVE_SHAPE = 3'd2;
  localparam logic [2:0] REG_OUTPUT_LOW  = 3'd3;
  localparam logic [2:0] REG_OUTPUT_HIGH = 3'd4;

  typedef logic [NORM_BITS:0] norm_t;

endpackage

>>> rtl/core/cmap_div.sv
module cmap_div
  import cmap_pkg::*;
#(
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [VW:0]   in_num,
  input  logic [VW:0]   in_den,
  output logic          out_valid,
  output norm_t         out_t
);

  localparam int NB = NORM_BITS;

  logic          v_r    [0:NB];
  logic          zero_r [0:NB];
  logic          one_r  [0:NB];
  logic [VW-1:0] rem_r  [0:NB];
  logic [VW-1:0] ud_r   [0:NB];
  logic [NB-1:0] q_r    [0:NB];

  logic          num_neg;
  logic          den_neg;
  logic [VW:0]   un_full;
  logic [VW:0]   ud_full;
  logic          zero_nxt;
  logic          one_nxt;

  always_comb begin
    num_neg  = in_num[VW];
    den_neg  = in_den[VW];
    un_full  = num_neg ? (~in_num + 1'b1) : in_num;
    ud_full  = den_neg ? (~in_den + 1'b1) : in_den;
    zero_nxt = (in_den == '0) || (in_num == '0) || (num_neg != den_neg);
    one_nxt  = un_full[VW-1:0] >= ud_full[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      zero_r[0] <= zero_nxt;
      one_r[0]  <= one_nxt;
      rem_r[0]  <= un_full[VW-1:0];
      ud_r[0]   <= ud_full[VW-1:0];
      q_r[0]    <= '0;
    end
  end

  // One restoring quotient bit per stage.
  for (genvar k = 1; k <= NB; k++) begin : g_step
    logic [VW:0]   rem2;
    logic          ge;
    logic [VW:0]   diff;
    logic [VW-1:0] rem_nxt;

    always_comb begin
      rem2    = {rem_r[k-1], 1'b0};
      diff    = rem2 - {1'b0, ud_r[k-1]};
      ge      = rem2 >= {1'b0, ud_r[k-1]};
      rem_nxt = ge ? diff[VW-1:0] : rem2[VW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
      if (en) begin
        zero_r[k] <= zero_r[k-1];
        one_r[k]  <= one_r[k-1];
        rem_r[k]  <= rem_nxt;
        ud_r[k]   <= ud_r[k-1];
        q_r[k]    <= {q_r[k-1][NB-2:0], ge};
      end
    end
  end

  assign out_valid = v_r[NB];
  assign out_t     = zero_r[NB] ? '0 : (one_r[NB] ? NORM_ONE : {1'b0, q_r[NB]});

endmodule

>>> rtl/core/cmap_shape.sv
module cmap_shape
  import cmap_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [2:0] curve,
  input  logic       in_valid,
  input  norm_t      in_t,
  output logic       out_valid,
  output norm_t      out_c
);

  localparam int D = NORM_W;

  logic        v_r    [0:D];
  norm_t       t_r    [0:D];
  norm_t       root_r [0:D];
  logic [34:0] srem_r [0:D];
  logic [33:0] tt_r   [0:D];
  norm_t       u_r    [0:D];
  logic [51:0] sm_r   [0:D];
  norm_t       smc_r  [0:D];
  logic [30:0] hr_r   [0:D];
  logic [47:0] sp_r   [0:D];
  norm_t       sn_r   [0:D];
  logic        ov_r;
  norm_t       c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      t_r[0]    <= in_t;
      root_r[0] <= '0;
      srem_r[0] <= {2'b00, in_t, {NORM_BITS{1'b0}}};
      tt_r[0]   <= '0;
      u_r[0]    <= '0;
      sm_r[0]   <= '0;
      smc_r[0]  <= '0;
      hr_r[0]   <= '0;
      sp_r[0]   <= '0;
      sn_r[0]   <= '0;
    end
  end

  // Square root takes one result bit per stage; the polynomial lanes run
  // alongside in the early stages and ride along afterward.
  for (genvar k = 1; k <= D; k++) begin : g_stage
    localparam int BI = D - k;
    logic [34:0] add;
    logic        ge;
    logic [34:0] srem_nxt;
    norm_t       root_nxt;
    logic [33:0] tt_nxt;
    norm_t       u_nxt;
    logic [51:0] sm_nxt;
    norm_t       smc_nxt;
    logic [30:0] hr_nxt;
    logic [47:0] sp_nxt;
    norm_t       sn_nxt;
    logic [33:0] rnd;
    logic [47:0] hp;
    logic [51:0] smr;
    logic [47:0] spr;

    always_comb begin
      add      = ({18'b0, root_r[k-1]} << (BI + 1)) + (35'd1 << (2 * BI));
      ge       = srem_r[k-1] >= add;
      srem_nxt = ge ? (srem_r[k-1] - add) : srem_r[k-1];
      root_nxt = ge ? (root_r[k-1] | (norm_t'(1) << BI)) : root_r[k-1];

      tt_nxt  = tt_r[k-1];
      u_nxt   = u_r[k-1];
      sm_nxt  = sm_r[k-1];
      smc_nxt = smc_r[k-1];
      hr_nxt  = hr_r[k-1];
      sp_nxt  = sp_r[k-1];
      sn_nxt  = sn_r[k-1];
      rnd     = tt_r[k-1] + 34'h8000;
      hp      = 48'(u_r[k-1]) * 48'(hr_r[k-1]);
      smr     = sm_r[k-1] + 52'h8000_0000;
      spr     = sp_r[k-1] + 48'h2000_0000;

      if (k == 1) tt_nxt = 34'(t_r[k-1]) * 34'(t_r[k-1]);
      if (k == 2) u_nxt = rnd[32:16];
      if (k == 3) begin
        sm_nxt = 52'(tt_r[k-1]) * 52'(18'h30000 - {t_r[k-1], 1'b0});
        hp     = 48'(u_r[k-1]) * 48'(SIN_C9);
        hr_nxt = SIN_C7 - hp[46:16];
      end
      if (k == 4) begin
        smc_nxt = smr[48:32];
        hr_nxt  = SIN_C5 - hp[46:16];
      end
      if (k == 5) hr_nxt = SIN_C3 - hp[46:16];
      if (k == 6) hr_nxt = SIN_C1 - hp[46:16];
      if (k == 7) sp_nxt = 48'(t_r[k-1]) * 48'(hr_r[k-1]);
      if (k == 8) sn_nxt = (spr[47:30] > 18'(NORM_ONE)) ? NORM_ONE : spr[46:30];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
      if (en) begin
        t_r[k]    <= t_r[k-1];
        root_r[k] <= root_nxt;
        srem_r[k] <= srem_nxt;
        tt_r[k]   <= tt_nxt;
        u_r[k]    <= u_nxt;
        sm_r[k]   <= sm_nxt;
        smc_r[k]  <= smc_nxt;
        hr_r[k]   <= hr_nxt;
        sp_r[k]   <= sp_nxt;
        sn_r[k]   <= sn_nxt;
      end
    end
  end

  norm_t c_nxt;

  always_comb begin
    unique case (curve)
      CURVE_SQUARE: c_nxt = u_r[D];
      CURVE_SQRT:   c_nxt = root_r[D];
      CURVE_SMOOTH: c_nxt = smc_r[D];
      CURVE_SINE:   c_nxt = sn_r[D];
      default:      c_nxt = t_r[D];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= v_r[D];
    end
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_c     = c_r;

endmodule

>>> rtl/core/curved_range_mapper_top.sv
// Maps each signed Q16.16 parameter word to a curved, rescaled Q16.16 word.
// One word is taken every cycle while the output is not stalled; the depth
// comes from the 16-stage quotient pipeline of the normalizer and the
// 17-stage root pipeline of the curve unit, plus setup and scaling
// stages. A stalled output freezes the whole pipeline, so in_stall follows
// out_stall while a result is waiting. The user must write registers through
// the cfg port only while no word is in flight; the block does not enforce it.
module curved_range_mapper_top
  import cmap_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [VALUE_WIDTH-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] in_param_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] out_mapped_out,
  output logic                   out_saturated
);

  localparam int VW = VALUE_WIDTH;

  logic [VW-1:0] input_low_r;
  logic [VW-1:0] input_high_r;
  logic [2:0]    curve_shape_r;
  logic [VW-1:0] output_low_r;
  logic [VW-1:0] output_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_low_r   <= '0;
      input_high_r  <= VW'(NORM_ONE);
      curve_shape_r <= CURVE_LINEAR;
      output_low_r  <= '0;
      output_high_r <= VW'(NORM_ONE);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INPUT_LOW:   input_low_r   <= cfg_data;
        REG_INPUT_HIGH:  input_high_r  <= cfg_data;
        REG_CURVE_SHAPE: curve_shape_r <= cfg_data[2:0];
        REG_OUTPUT_LOW:  output_low_r  <= cfg_data;
        REG_OUTPUT_HIGH: output_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output span is static between items; keep its magnitude registered.
  logic [VW:0] diff_w;
  logic [VW:0] diff_mag_r;
  logic        diff_neg_r;

  assign diff_w = {output_high_r[VW-1], output_high_r} - {output_low_r[VW-1], output_low_r};

  always_ff @(posedge clk) begin
    diff_neg_r <= diff_w[VW];
    diff_mag_r <= diff_w[VW] ? (~diff_w + 1'b1) : diff_w;
  end

  logic en;
  logic out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // Setup stage: offset and span of the input range.
  logic        s0_valid_r;
  logic [VW:0] num_r;
  logic [VW:0] den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
    end
    if (en) begin
      num_r <= {in_param_in[VW-1], in_param_in} - {input_low_r[VW-1], input_low_r};
      den_r <= {input_high_r[VW-1], input_high_r} - {input_low_r[VW-1], input_low_r};
    end
  end

  logic  t_valid;
  norm_t t_w;

  cmap_div #(.VW(VW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_valid_r),
    .in_num    (num_r),
    .in_den    (den_r),
    .out_valid (t_valid),
    .out_t     (t_w)
  );

  logic  c_valid;
  norm_t c_w;

  cmap_shape u_shape (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .curve     (curve_shape_r),
    .in_valid  (t_valid),
    .in_t      (t_w),
    .out_valid (c_valid),
    .out_c     (c_w)
  );

  // Scale stage: span times curved fraction.
  logic           s1_valid_r;
  logic           s1_full_r;
  logic [VW+17:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= c_valid;
    end
    if (en) begin
      s1_full_r <= c_w[NORM_BITS];
      prod_r    <= (VW+18)'(diff_mag_r) * (VW+18)'(c_w);
    end
  end

  // Offset, round and saturate.
  logic [VW+17:0] prod_rnd;
  logic [VW+2:0]  q_ext;
  logic [VW+2:0]  lo_ext;
  logic [VW+2:0]  res;
  logic           ovf;
  logic [VW-1:0]  mapped_nxt;
  logic [VW-1:0]  vmax;
  logic [VW-1:0]  vmin;
  logic [VW-1:0]  mapped_r;
  logic           sat_r;

  assign vmax = {1'b0, {(VW-1){1'b1}}};
  assign vmin = {1'b1, {(VW-1){1'b0}}};

  always_comb begin
    prod_rnd = prod_r + (VW+18)'(16'h8000);
    q_ext    = {1'b0, prod_rnd[VW+17:16]};
    lo_ext   = {{3{output_low_r[VW-1]}}, output_low_r};
    if (s1_full_r) begin
      res = {{3{output_high_r[VW-1]}}, output_high_r};
    end else if (diff_neg_r) begin
      res = lo_ext - q_ext;
    end else begin
      res = lo_ext + q_ext;
    end
    ovf = !((res[VW+2:VW-1] == '0) || (res[VW+2:VW-1] == '1));
    if (ovf) begin
      mapped_nxt = res[VW+2] ? vmin : vmax;
    end else begin
      mapped_nxt = res[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s1_valid_r;
    end
    if (en) begin
      mapped_r <= mapped_nxt;
      sat_r    <= ovf;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mapped_out = mapped_r;
  assign out_saturated  = sat_r;

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

  a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (out_mapped_out == vmax || out_mapped_out == vmin))
    else $error("saturated word not at a rail");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(s1_valid_r) && $stable(prod_r)))
    else $error("scale stage moved while output stalled");
`endif

endmodule
